[rtl/lft_pkg.sv]
// Shared constants and types for the LRU flow table.
// No dependencies; every other file imports this package.
`default_nettype none
package lft_pkg;
	localparam int CAPACITY     = 256;
	localparam int KEY_BITS     = 48;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_W        = $clog2(CAPACITY);
	localparam int CNT_W        = IDX_W + 1;
	localparam int MAX_W        = 9;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_TOUCH  = 2'd2,
		OP_DELETE = 2'd3
	} op_t;
endpackage
`default_nettype wire

[rtl/lft_req_if.sv]
// Request channel of the LRU flow table: valid, ready and one operation.
// Depends on lft_pkg.
`default_nettype none
interface lft_req_if import lft_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              opcode;
	logic [KEY_BITS-1:0]     key;
	logic [PAYLOAD_BITS-1:0] value;
	modport source (output valid, opcode, key, value, input ready);
	modport sink (input valid, opcode, key, value, output ready);
endinterface
`default_nettype wire

[rtl/lft_rsp_if.sv]
// Response channel of the LRU flow table: valid, ready and one result.
// Depends on lft_pkg.
`default_nettype none
interface lft_rsp_if import lft_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic [PAYLOAD_BITS-1:0] result_value;
	logic                    evicted;
	logic [KEY_BITS-1:0]     evicted_key;
	modport source (output valid, found, result_value, evicted, evicted_key, input ready);
	modport sink (input valid, found, result_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

[rtl/lru_flow_table.sv]
// Top level of the LRU flow table: slot memories, recency ranks and sequencer.
// Depends on lft_pkg, lft_req_if and lft_rsp_if.
`default_nettype none
// Entries sit in one slot memory (key and payload) with a recency rank per
// slot in a second memory, rank 0 being least recent. A first sweep reads every
// slot to find the key, the least recent entry and a free slot; a second sweep
// renumbers ranks and is skipped when no rank changes; a final state writes the
// chosen slot. Both sweeps go slot by slot because each memory has a single
// read port. A new request is taken while the previous response still waits
// to be taken.
module lru_flow_table import lft_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [MAX_W-1:0] cfg_wdata,
	lft_req_if.sink               req,
	lft_rsp_if.source             rsp
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN1, ST_DRAIN1, ST_DEC, ST_SCAN2, ST_DRAIN2, ST_FIN
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	// Memories.
	logic [KEY_BITS+PAYLOAD_BITS-1:0] kv_mem [CAPACITY];
	logic [IDX_W-1:0]                 rank_mem [CAPACITY];

	state_t                    state_q;
	logic [IDX_W-1:0]          cnt_q;
	logic [CAPACITY-1:0]       valid_q;
	logic [CNT_W-1:0]          count_q;
	logic [MAX_W-1:0]          max_q;

	logic [1:0]                op_q;
	logic [KEY_BITS-1:0]       key_q;
	logic [PAYLOAD_BITS-1:0]   val_q;

	logic                      vld_s1;
	logic                      ph2_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [KEY_BITS+PAYLOAD_BITS-1:0] kv_s1;
	logic [IDX_W-1:0]          rank_s1;

	logic                      hit_q;
	logic [IDX_W-1:0]          hslot_q;
	logic [IDX_W-1:0]          hrank_q;
	logic [PAYLOAD_BITS-1:0]   hpay_q;
	logic                      free_ok_q;
	logic [IDX_W-1:0]          fslot_q;
	logic [IDX_W-1:0]          zslot_q;
	logic [KEY_BITS-1:0]       zkey_q;

	logic                      wr_en_q;
	logic [IDX_W-1:0]          wr_slot_q;
	logic [IDX_W-1:0]          wr_rank_q;
	logic [PAYLOAD_BITS-1:0]   wr_pay_q;
	logic                      set_v_q;
	logic                      clr_v_q;
	logic                      dec_q;
	logic [IDX_W-1:0]          thr_q;
	logic [CNT_W-1:0]          cnt_nx_q;

	logic                      res_found_q;
	logic [PAYLOAD_BITS-1:0]   res_val_q;
	logic                      res_ev_q;
	logic [KEY_BITS-1:0]       res_evkey_q;

	logic                      out_valid_q;
	logic                      out_found_q;
	logic [PAYLOAD_BITS-1:0]   out_val_q;
	logic                      out_ev_q;
	logic [KEY_BITS-1:0]       out_evkey_q;

	logic [CNT_W-1:0]          lim;
	logic                      over;
	logic                      fin_go;
	logic                      rank_we;
	logic [IDX_W-1:0]          rank_wa;
	logic [IDX_W-1:0]          rank_wd;

	// Effective limit and whether one more entry would exceed it.
	always_comb begin
		if (int'(max_q) > CAPACITY) begin
			lim = CNT_W'(CAPACITY);
		end else begin
			lim = CNT_W'(max_q);
		end
		over = ({1'b0, count_q} + (CNT_W+1)'(1)) > {1'b0, lim};
	end

	assign req.ready = (state_q == ST_IDLE);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	// Rank write port: renumbering during the second sweep, target slot at the end.
	always_comb begin
		rank_we = 1'b0;
		rank_wa = idx_s1;
		rank_wd = rank_s1 - IDX_W'(1);
		if (vld_s1 && ph2_s1 && valid_q[idx_s1] && (rank_s1 > thr_q)) begin
			rank_we = 1'b1;
		end else if (fin_go && wr_en_q) begin
			rank_we = 1'b1;
			rank_wa = wr_slot_q;
			rank_wd = wr_rank_q;
		end
	end

	// Memory read and write ports.
	always_ff @(posedge clk) begin
		kv_s1   <= kv_mem[cnt_q];
		rank_s1 <= rank_mem[cnt_q];
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
		if (fin_go && wr_en_q) begin
			kv_mem[wr_slot_q] <= {key_q, wr_pay_q};
		end
	end

	// Request and decision payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			val_q <= req.value;
		end
		idx_s1 <= cnt_q;
		// First sweep: find the key, the least recent entry and a free slot.
		if (vld_s1 && !ph2_s1) begin
			if (valid_q[idx_s1]) begin
				if (kv_s1[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS] == key_q) begin
					hslot_q <= idx_s1;
					hrank_q <= rank_s1;
					hpay_q  <= kv_s1[PAYLOAD_BITS-1:0];
				end
				if (rank_s1 == '0) begin
					zslot_q <= idx_s1;
					zkey_q  <= kv_s1[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS];
				end
			end else if (!free_ok_q) begin
				fslot_q <= idx_s1;
			end
		end
		// Work out the update once the sweep is complete.
		if (state_q == ST_DEC) begin
			wr_en_q     <= 1'b0;
			wr_slot_q   <= hslot_q;
			wr_rank_q   <= IDX_W'(count_q - CNT_W'(1));
			wr_pay_q    <= hpay_q;
			set_v_q     <= 1'b0;
			clr_v_q     <= 1'b0;
			dec_q       <= 1'b0;
			thr_q       <= hrank_q;
			cnt_nx_q    <= count_q;
			res_found_q <= hit_q;
			res_val_q   <= '0;
			res_ev_q    <= 1'b0;
			res_evkey_q <= '0;
			unique case (op_t'(op_q))
				OP_PUT: begin
					if (hit_q) begin
						wr_en_q  <= 1'b1;
						wr_pay_q <= val_q;
						dec_q    <= 1'b1;
					end else if (over && count_q != '0) begin
						// Replace the least recent entry with the new key.
						wr_en_q     <= 1'b1;
						wr_slot_q   <= zslot_q;
						wr_pay_q    <= val_q;
						dec_q       <= 1'b1;
						thr_q       <= '0;
						res_ev_q    <= 1'b1;
						res_evkey_q <= zkey_q;
					end else if (over) begin
						// Empty table with a zero limit evicts the new key itself.
						res_ev_q    <= 1'b1;
						res_evkey_q <= key_q;
					end else begin
						wr_en_q   <= 1'b1;
						wr_slot_q <= fslot_q;
						wr_rank_q <= IDX_W'(count_q);
						wr_pay_q  <= val_q;
						set_v_q   <= 1'b1;
						cnt_nx_q  <= count_q + CNT_W'(1);
					end
				end
				OP_GET: begin
					if (hit_q) begin
						wr_en_q   <= 1'b1;
						dec_q     <= 1'b1;
						res_val_q <= hpay_q;
					end
				end
				OP_TOUCH: begin
					if (hit_q) begin
						wr_en_q <= 1'b1;
						dec_q   <= 1'b1;
					end
				end
				OP_DELETE: begin
					if (hit_q) begin
						clr_v_q  <= 1'b1;
						dec_q    <= 1'b1;
						cnt_nx_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer, control registers and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			max_q       <= MAX_W'(256);
			vld_s1      <= 1'b0;
			ph2_s1      <= 1'b0;
			hit_q       <= 1'b0;
			free_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_val_q   <= '0;
			out_ev_q    <= 1'b0;
			out_evkey_q <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			// A new response loaded in the same cycle keeps the register full.
			if (rsp.valid && rsp.ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end
			// The second sweep only carries data when ranks change.
			vld_s1 <= (state_q == ST_SCAN1) || ((state_q == ST_SCAN2) && dec_q);
			ph2_s1 <= (state_q == ST_SCAN2);
			if (vld_s1 && !ph2_s1 && valid_q[idx_s1]) begin
				if (kv_s1[KEY_BITS+PAYLOAD_BITS-1:PAYLOAD_BITS] == key_q) begin
					hit_q <= 1'b1;
				end
			end
			if (vld_s1 && !ph2_s1 && !valid_q[idx_s1]) begin
				free_ok_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req.valid) begin
						hit_q     <= 1'b0;
						free_ok_q <= 1'b0;
						state_q   <= ST_SCAN1;
					end
				end
				ST_SCAN1: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN1;
					end
				end
				ST_DRAIN1: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					cnt_q <= '0;
					state_q <= ST_SCAN2;
				end
				ST_SCAN2: begin
					// Sweep skips straight to the end when no rank changes.
					if (!dec_q) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
						if (cnt_q == LAST_IDX) begin
							state_q <= ST_DRAIN2;
						end
					end
				end
				ST_DRAIN2: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						if (set_v_q) begin
							valid_q[wr_slot_q] <= 1'b1;
						end
						if (clr_v_q) begin
							valid_q[hslot_q] <= 1'b0;
						end
						count_q     <= cnt_nx_q;
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_val_q   <= res_val_q;
						out_ev_q    <= res_ev_q;
						out_evkey_q <= res_evkey_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.result_value = out_val_q;
	assign rsp.evicted      = out_ev_q;
	assign rsp.evicted_key  = out_evkey_q;
endmodule
`default_nettype wire

[sim/tb_lru_flow_table.sv]
// Testbench for lru_flow_table: directed table, then random traffic per limit setting.
// Depends on lft_pkg, lft_req_if, lft_rsp_if and the lru_flow_table RTL.
`timescale 1ns / 100ps
module tb_lru_flow_table;
	import lft_pkg::*;

	localparam int DRAIN_CYCLES = 2 * CAPACITY + 100;
	localparam int STALL_LIMIT  = 20000;
	localparam int POOL_SIZE    = 12;

	typedef struct packed {
		logic                    found;
		logic [PAYLOAD_BITS-1:0] result_value;
		logic                    evicted;
		logic [KEY_BITS-1:0]     evicted_key;
	} flow_rsp_t;

	typedef struct {
		int                      limit;
		op_t                     op;
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] value;
		bit                      typed;
		flow_rsp_t               rsp;
	} flow_row_t;

	localparam logic [KEY_BITS-1:0]     KMAX = {KEY_BITS{1'b1}};
	localparam logic [PAYLOAD_BITS-1:0] VMAX = {PAYLOAD_BITS{1'b1}};
	localparam logic [KEY_BITS-1:0]     KA = 48'h0a0b_0c0d_1234;
	localparam logic [KEY_BITS-1:0]     KB = 48'h5555_aaaa_0050;
	localparam logic [KEY_BITS-1:0]     KC = 48'h8000_0000_0001;
	localparam logic [KEY_BITS-1:0]     KD = 48'h0000_ffff_0000;
	localparam logic [KEY_BITS-1:0]     KE = 48'h7fff_ffff_fffe;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [MAX_W-1:0] cfg_wdata = '0;

	lft_req_if req ();
	lft_rsp_if rsp ();

	lru_flow_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	// Shadow of the table, least recent entry at the front.
	logic [KEY_BITS-1:0]     shadow_keys[$];
	logic [PAYLOAD_BITS-1:0] shadow_vals[$];
	int                      shadow_limit = 256;
	flow_rsp_t               pending_rsps[$];
	logic [KEY_BITS-1:0]     key_pool[POOL_SIZE];

	int  errors = 0;
	int  stall_count = 0;
	bit  no_idle = 1'b0;
	bit  long_hold = 1'b0;

	always #5 clk = ~clk;

	initial begin
		req.valid  = 1'b0;
		req.opcode = OP_PUT;
		req.key    = '0;
		req.value  = '0;
		rsp.ready  = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("Mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Table behavior: lookup, update of recency order and eviction.
	function automatic flow_rsp_t table_update(op_t op, logic [KEY_BITS-1:0] k,
			logic [PAYLOAD_BITS-1:0] v);
		flow_rsp_t r;
		int pos;
		int eff;
		logic [PAYLOAD_BITS-1:0] pv;
		r = '0;
		pos = -1;
		eff = (shadow_limit > CAPACITY) ? CAPACITY : shadow_limit;
		foreach (shadow_keys[i])
			if (pos < 0 && shadow_keys[i] == k)
				pos = i;
		r.found = (pos >= 0);
		case (op)
			OP_PUT: begin
				if (pos >= 0) begin
					shadow_keys.delete(pos);
					shadow_vals.delete(pos);
					shadow_keys.push_back(k);
					shadow_vals.push_back(v);
				end else begin
					if (shadow_keys.size() >= CAPACITY) begin
						r.evicted = 1'b1;
						r.evicted_key = shadow_keys.pop_front();
						void'(shadow_vals.pop_front());
					end
					shadow_keys.push_back(k);
					shadow_vals.push_back(v);
					if (!r.evicted && shadow_keys.size() > eff) begin
						r.evicted = 1'b1;
						r.evicted_key = shadow_keys.pop_front();
						void'(shadow_vals.pop_front());
					end
				end
			end
			OP_GET, OP_TOUCH: begin
				if (pos >= 0) begin
					pv = shadow_vals[pos];
					if (op == OP_GET)
						r.result_value = pv;
					shadow_keys.delete(pos);
					shadow_vals.delete(pos);
					shadow_keys.push_back(k);
					shadow_vals.push_back(pv);
				end
			end
			default: begin
				if (pos >= 0) begin
					shadow_keys.delete(pos);
					shadow_vals.delete(pos);
				end
			end
		endcase
		return r;
	endfunction

	// Offer one request and hold it until the transfer; optional gap afterwards.
	task automatic send_op(input op_t op, input logic [KEY_BITS-1:0] k,
			input logic [PAYLOAD_BITS-1:0] v, input bit typed, input flow_rsp_t want);
		flow_rsp_t pred;
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.key    <= k;
		req.value  <= v;
		do @(posedge clk); while (!req.ready);
		pred = table_update(op, k, v);
		pending_rsps.push_back(typed ? want : pred);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Wait until all results are in and the block has finished its sweep.
	task automatic drain;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input int lim);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= lim[MAX_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_limit = lim;
	endtask

	function automatic logic [KEY_BITS-1:0] rand_key;
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[KEY_BITS-1:0];
	endfunction

	task automatic random_ops(input int count, input bit flood);
		op_t op;
		logic [KEY_BITS-1:0] k;
		int sel;
		foreach (key_pool[i])
			key_pool[i] = rand_key();
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (flood)
				op = (sel < 85) ? OP_PUT : op_t'($urandom_range(1, 3));
			else if (sel < 40)
				op = OP_PUT;
			else if (sel < 65)
				op = OP_GET;
			else if (sel < 80)
				op = OP_TOUCH;
			else
				op = OP_DELETE;
			if (flood && op == OP_PUT)
				k = rand_key();
			else if ($urandom_range(0, 99) < 85 && !flood)
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (flood && shadow_keys.size() != 0 && $urandom_range(0, 1))
				k = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
			else
				k = rand_key();
			send_op(op, k, $urandom, 1'b0, '0);
		end
	endtask

	// Receiver: random ready bursts, one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				rsp.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold = 1'b0;
			end else if (no_idle) begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		flow_rsp_t want;
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			stall_count <= 0;
		end else if (arst_n) begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
		if (rsp.valid && rsp.ready) begin
			if (pending_rsps.size() == 0) begin
				report_mismatch("unexpected result transfer", 64'd1, 64'd0);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.found !== want.found)
					report_mismatch("found", rsp.found, want.found);
				if (rsp.result_value !== want.result_value)
					report_mismatch("result_value", rsp.result_value, want.result_value);
				if (rsp.evicted !== want.evicted)
					report_mismatch("evicted", rsp.evicted, want.evicted);
				if (rsp.evicted_key !== want.evicted_key)
					report_mismatch("evicted_key", rsp.evicted_key, want.evicted_key);
			end
		end
	end

	// Directed table: the limit column is applied before its row.
	flow_row_t rows[] = '{
		'{256, OP_GET,    '0,   '0,            1, '{1'b0, '0, 1'b0, '0}},
		'{256, OP_TOUCH,  KMAX, '0,            1, '{1'b0, '0, 1'b0, '0}},
		'{256, OP_DELETE, '0,   '0,            1, '{1'b0, '0, 1'b0, '0}},
		'{256, OP_PUT,    '0,   VMAX,          1, '{1'b0, '0, 1'b0, '0}},
		'{256, OP_PUT,    KMAX, '0,            1, '{1'b0, '0, 1'b0, '0}},
		'{256, OP_GET,    '0,   '0,            1, '{1'b1, VMAX, 1'b0, '0}},
		'{256, OP_GET,    KMAX, VMAX,          1, '{1'b1, '0, 1'b0, '0}},
		'{256, OP_PUT,    '0,   32'h1234_5678, 1, '{1'b1, '0, 1'b0, '0}},
		'{256, OP_TOUCH,  KMAX, '0,            1, '{1'b1, '0, 1'b0, '0}},
		'{256, OP_DELETE, '0,   '0,            1, '{1'b1, '0, 1'b0, '0}},
		'{256, OP_GET,    '0,   '0,            1, '{1'b0, '0, 1'b0, '0}},
		'{1,   OP_PUT,    KA,   32'hcafe_0001, 1, '{1'b0, '0, 1'b1, KMAX}},
		'{1,   OP_PUT,    KA,   32'hcafe_0002, 1, '{1'b1, '0, 1'b0, '0}},
		'{1,   OP_GET,    KA,   '0,            0, '0},
		'{1,   OP_PUT,    KB,   32'h0000_0001, 1, '{1'b0, '0, 1'b1, KA}},
		'{0,   OP_PUT,    KC,   32'h8000_0000, 1, '{1'b0, '0, 1'b1, KB}},
		'{0,   OP_PUT,    KD,   32'h0000_00ff, 1, '{1'b0, '0, 1'b1, KC}},
		'{0,   OP_PUT,    KD,   32'h0000_0100, 1, '{1'b1, '0, 1'b0, '0}},
		'{0,   OP_GET,    KD,   '0,            0, '0},
		'{0,   OP_DELETE, KD,   '0,            1, '{1'b1, '0, 1'b0, '0}},
		'{0,   OP_PUT,    KE,   32'h5a5a_a5a5, 1, '{1'b0, '0, 1'b1, KE}},
		'{0,   OP_GET,    KE,   '0,            1, '{1'b0, '0, 1'b0, '0}},
		'{511, OP_PUT,    KA,   VMAX,          1, '{1'b0, '0, 1'b0, '0}},
		'{511, OP_TOUCH,  KB,   '0,            1, '{1'b0, '0, 1'b0, '0}}
	};

	// Main sequence: reset, directed rows, random phases at several limits.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].limit != shadow_limit)
				set_limit(rows[i].limit);
			send_op(rows[i].op, rows[i].key, rows[i].value, rows[i].typed, rows[i].rsp);
		end
		set_limit(3);
		long_hold = 1'b1;
		random_ops(80, 1'b0);
		set_limit(1);
		random_ops(60, 1'b0);
		set_limit(0);
		random_ops(50, 1'b0);
		set_limit(511);
		random_ops(290, 1'b1);
		set_limit(256);
		random_ops(80, 1'b0);
		set_limit(16);
		random_ops(80, 1'b0);
		// Sender pauses until every result is back, then resumes.
		drain();
		random_ops(40, 1'b0);
		set_limit(2);
		random_ops(80, 1'b0);
		set_limit($urandom_range(4, 10));
		no_idle = 1'b1;
		random_ops(100, 1'b0);
		drain();
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[filelist.f]
rtl/lft_pkg.sv
rtl/lft_req_if.sv
rtl/lft_rsp_if.sv
rtl/lru_flow_table.sv
sim/tb_lru_flow_table.sv
